// ===== design/segmented_byte_memory_assert.svh =====
// Assertion macros for the segmented byte memory.
// Included by sbm_back, which carries the concurrent checks; no other dependencies.
`ifndef SEGMENTED_BYTE_MEMORY_ASSERT_SVH
`define SEGMENTED_BYTE_MEMORY_ASSERT_SVH

`ifndef SYNTHESIS

// expr must never be true outside reset
`define SBM_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

// cons holds in the same cycle as ante
`define SBM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons holds in the cycle after ante
`define SBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SBM_ASSERT_NEVER(label, clk, rst, expr)
`define SBM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SBM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/sbm_pkg.sv =====
// Shared constants, types and codes for the segmented byte memory.
// No dependencies; every other file but the assertion macro header imports this package.
package sbm_pkg;

  // memory geometry
  localparam int MEM_BYTES    = 16384;
  localparam int NUM_SEGMENTS = 8;
  localparam int NUM_BANKS    = 4;
  localparam int LANE_W       = $clog2(NUM_BANKS);
  localparam int ADDR_W       = $clog2(MEM_BYTES);
  localparam int ROWS         = MEM_BYTES / NUM_BANKS;
  localparam int ROW_W        = $clog2(ROWS);

  // field widths
  localparam int CODE_W = 15;
  localparam int SEG_W  = 16;
  localparam int OFF_W  = 16;
  localparam int PHYS_W = 17;
  localparam int END_W  = PHYS_W + 1;
  localparam int DATA_W = 32;

  // segment table
  localparam logic [SEG_W-1:0]  SEG_CODE     = 16'd0;
  localparam logic [SEG_W-1:0]  SEG_DATA     = 16'd1;
  localparam logic [SEG_W-1:0]  SEG_COUNT    = SEG_W'(NUM_SEGMENTS);
  localparam logic [PHYS_W-1:0] UNUSED_BASE  = 17'h0FFFF;
  localparam logic [END_W-1:0]  UNUSED_END   = 18'h0FFFF + 18'h0FFFF;
  localparam logic [END_W-1:0]  MEM_END      = END_W'(MEM_BYTES);

  // queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ_BYTE  = 2'd0,
    OP_READ_WORD  = 2'd1,
    OP_WRITE_BYTE = 2'd2,
    OP_WRITE_WORD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_INDEX  = 2'd1,
    ST_BEYOND_MEM = 2'd2,
    ST_SEG_FAULT  = 2'd3
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    opcode_t              op;
    status_t              status;
    logic [PHYS_W-1:0]    phys;
    logic [DATA_W-1:0]    wdata;
  } task_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== design/sbm_if.sv =====
// Valid/ready channel interfaces: request, response and configuration.
// Depends on sbm_pkg.
interface sbm_req_if;
  import sbm_pkg::*;
  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [DATA_W-1:0]    logical_address;
  logic [DATA_W-1:0]    write_data;
  modport source (output valid, opcode, logical_address, write_data, input ready);
  modport sink   (input valid, opcode, logical_address, write_data, output ready);
endinterface

interface sbm_rsp_if;
  import sbm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    read_data;
  logic [PHYS_W-1:0]    physical_address;
  status_t              status;
  modport source (output valid, read_data, physical_address, status, input ready);
  modport sink   (input valid, read_data, physical_address, status, output ready);
endinterface

interface sbm_cfg_if;
  import sbm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_W-1:0]    code_size;
  modport source (output valid, code_size, input ready);
  modport sink   (input valid, code_size, output ready);
endinterface

// ===== design/sbm_queue.sv =====
// Short FIFO of classified requests between front and back.
// Depends on sbm_pkg.
module sbm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbm_pkg::task_t    push_data,
  input  logic              pop,
  output sbm_pkg::task_t    pop_data,
  output sbm_pkg::q_stat_t  stat
);
  import sbm_pkg::*;

  task_t               entries [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;

  assign stat.full      = (count == QCNT_W'(QDEPTH));
  assign stat.not_empty = (count != '0);
  assign pop_data       = entries[rptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/sbm_front.sv =====
// Front end: holds code_size, accepts requests, translates and checks them.
// Depends on sbm_pkg and sbm_if; feeds sbm_queue.
module sbm_front (
  input  logic                 clk,
  input  logic                 rst,
  sbm_req_if.sink              req,
  sbm_cfg_if.sink              cfg,
  input  sbm_pkg::q_stat_t     q_stat,
  input  sbm_pkg::back_stat_t  back_stat,
  output logic                 push,
  output sbm_pkg::task_t       push_data
);
  import sbm_pkg::*;

  logic [CODE_W-1:0]  code_size;
  logic [SEG_W-1:0]   idx;
  logic [OFF_W-1:0]   off;
  logic [PHYS_W-1:0]  base;
  logic [END_W-1:0]   seg_end;
  logic [PHYS_W-1:0]  phys;
  logic [END_W-1:0]   last;
  logic               bad_index;
  logic               beyond;
  logic               fault;

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      code_size <= '0;
    end else if (cfg.valid) begin
      code_size <= cfg.code_size;
    end
  end

  // accept while there is queue room and memory is not being cleared
  assign req.ready = !q_stat.full && !back_stat.clearing;
  assign push      = req.valid && req.ready;

  assign idx = req.logical_address[DATA_W-1 -: SEG_W];
  assign off = req.logical_address[OFF_W-1:0];

  // segment table lookup: base and end of segment
  always_comb begin
    if (idx == SEG_CODE) begin
      base    = '0;
      seg_end = END_W'(code_size);
    end else if (idx == SEG_DATA) begin
      base    = PHYS_W'(code_size);
      seg_end = (END_W'(code_size) >= MEM_END) ? END_W'(code_size) : MEM_END;
    end else begin
      base    = UNUSED_BASE;
      seg_end = UNUSED_END;
    end
  end

  // translation and range checks
  assign phys      = base + PHYS_W'(off);
  assign last      = END_W'(phys) + (req.opcode[0] ? END_W'(4) : END_W'(1));
  assign bad_index = (idx >= SEG_COUNT);
  assign beyond    = (END_W'(phys) >= MEM_END) || (last > MEM_END);
  assign fault     = (last > seg_end);

  always_comb begin
    push_data.op    = req.opcode;
    push_data.wdata = req.write_data;
    push_data.phys  = bad_index ? '0 : phys;
    if (bad_index) begin
      push_data.status = ST_BAD_INDEX;
    end else if (beyond) begin
      push_data.status = ST_BEYOND_MEM;
    end else if (fault) begin
      push_data.status = ST_SEG_FAULT;
    end else begin
      push_data.status = ST_OK;
    end
  end

endmodule

// ===== design/sbm_back.sv =====
// Back end: four byte banks, clearing pass after reset, response register.
// Depends on sbm_pkg, sbm_if and the assertion macro header.
`include "segmented_byte_memory_assert.svh"

module sbm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sbm_pkg::task_t       head,
  input  sbm_pkg::q_stat_t     q_stat,
  output logic                 pop,
  output sbm_pkg::back_stat_t  back_stat,
  sbm_rsp_if.source            rsp
);
  import sbm_pkg::*;

  logic                 clearing;
  logic [ROW_W-1:0]     clear_row;
  logic                 issue;
  logic                 ok_op;
  logic [LANE_W-1:0]    lane;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     bank_row [NUM_BANKS];
  logic                 bank_we  [NUM_BANKS];
  logic [7:0]           bank_wd  [NUM_BANKS];
  logic [7:0]           bank_rd  [NUM_BANKS];

  // request in flight between memory access and response register
  logic                 pend_valid;
  task_t                pend;
  logic [DATA_W-1:0]    pend_rd;

  // response register
  logic                 out_valid;
  logic [DATA_W-1:0]    out_read_data;
  logic [PHYS_W-1:0]    out_phys;
  status_t              out_status;

  // clearing pass: one row of all banks per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + 1'b1;
      if (clear_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end
  assign back_stat.clearing = clearing;

  // issue one request when the path to the response register is free
  assign issue = q_stat.not_empty && !clearing && !pend_valid && (!out_valid || rsp.ready);
  assign pop   = issue;
  assign ok_op = (head.status == ST_OK);
  assign lane  = head.phys[LANE_W-1:0];
  assign row   = head.phys[ADDR_W-1:LANE_W];

  // bank addressing: banks below the start lane take the next row
  always_comb begin
    logic [LANE_W-1:0] k;
    for (int b = 0; b < NUM_BANKS; b++) begin
      k = LANE_W'(b) - lane;
      if (clearing) begin
        bank_row[b] = clear_row;
        bank_we[b]  = 1'b1;
        bank_wd[b]  = '0;
      end else begin
        bank_row[b] = row + ROW_W'(LANE_W'(b) < lane);
        bank_we[b]  = issue && ok_op && head.op[1] && (head.op[0] || LANE_W'(b) == lane);
        bank_wd[b]  = head.op[0] ? head.wdata[8*(NUM_BANKS-1-int'(k)) +: 8]
                                 : head.wdata[7:0];
      end
    end
  end

  // byte banks with registered read
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[bank_row[b]] <= bank_wd[b];
      end
      bank_rd[b] <= mem[bank_row[b]];
    end
  end

  // pending stage holds the request while its read data comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue;
    end
  end
  always_ff @(posedge clk) begin
    if (issue) begin
      pend <= head;
    end
  end

  // assemble read data, big-endian from the start lane
  always_comb begin
    logic [LANE_W-1:0] l;
    logic [DATA_W-1:0] word;
    l    = pend.phys[LANE_W-1:0];
    word = '0;
    for (int j = 0; j < NUM_BANKS; j++) begin
      word[8*(NUM_BANKS-1-j) +: 8] = bank_rd[LANE_W'(l + LANE_W'(j))];
    end
    if (pend.status != ST_OK || pend.op[1]) begin
      pend_rd = '0;
    end else if (pend.op[0]) begin
      pend_rd = word;
    end else begin
      pend_rd = DATA_W'(bank_rd[l]);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (pend_valid) begin
      out_read_data <= pend_rd;
      out_phys      <= pend.phys;
      out_status    <= pend.status;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.read_data        = out_read_data;
  assign rsp.physical_address = out_phys;
  assign rsp.status           = out_status;

  // no request is issued during the clearing pass
  `SBM_ASSERT_NEVER(a_no_issue_clearing, clk, rst, issue && clearing)
  // a pending request always lands in the response register
  `SBM_ASSERT_NEXT(a_pend_lands, clk, rst, pend_valid, out_valid)
  // memory is only written by the clearing pass or a checked write
  `SBM_ASSERT_IMPLY(a_write_checked, clk, rst, bank_we[0] && !clearing,
                    issue && ok_op && head.op[1])
  // a failed check returns zero data
  `SBM_ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && out_status != ST_OK,
                    out_read_data == '0)

endmodule

// ===== design/segmented_byte_memory.sv =====
// Path: an accepted request is written into the queue, issued to the banks with its read
// data registered alongside the pending stage, then captured in the response register.
// Issue waits while the pending stage is full or the response register holds an untaken
// response. Reset: code_size clears to 0; the banks are zeroed by a clearing pass over all
// 4096 rows (one row of four bytes a cycle) during which no request is accepted.
module segmented_byte_memory (
  input  logic     clk,
  input  logic     rst,
  sbm_req_if.sink  req,
  sbm_cfg_if.sink  cfg,
  sbm_rsp_if.source rsp
);
  import sbm_pkg::*;

  logic        push;
  logic        pop;
  task_t       push_data;
  task_t       head;
  q_stat_t     q_stat;
  back_stat_t  back_stat;

  // request classification
  sbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .back_stat (back_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  sbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .stat      (q_stat)
  );

  // memory access and response
  sbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .back_stat (back_stat),
    .rsp       (rsp)
  );

endmodule
